// File: rtl/smafc_pkg.sv
`default_nettype none
package smafc_pkg;

    localparam int WINDOW_LEN  = 50;
    localparam int SAMPLE_BITS = 16;
    localparam int AVG_W       = 16;
    localparam int FAULT_W     = 8;
    localparam int FAULT_MAX   = 255;

    localparam int IDX_W  = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam int CNT_W  = $clog2(WINDOW_LEN + 1);
    localparam int SUM_W  = SAMPLE_BITS + CNT_W;
    localparam int REM_W  = CNT_W + 1;
    localparam int STEP_W = $clog2(SUM_W + 1);

    typedef logic [SAMPLE_BITS-1:0] sample_t;
    typedef logic [SUM_W-1:0]       sum_t;
    typedef logic [IDX_W-1:0]       idx_t;
    typedef logic [CNT_W-1:0]       cnt_t;

endpackage
`default_nettype wire

// File: rtl/smafc_ram.sv
`default_nettype none
module smafc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 50
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule
`default_nettype wire

// File: rtl/speed_moving_average_with_fault_count_core.sv
`default_nettype none
// A failed read goes from acceptance straight to the result stage; a good read first updates
// the sum, reading out the oldest sample once the window is full, then runs the 22-step
// one-bit-per-cycle divider. A new read is accepted only once the previous result is issued;
// a result that has not been taken holds the block in its last state until the output frees.
// Reset (aresetn low, synchronous) empties the window, clears the sum, the stored
// average and the fault count; the sample memory itself is not cleared.
module speed_moving_average_with_fault_count_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [15:0] rpm_sample
    input  wire logic        s_tuser,   // [0] read_ok
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [23:0] m_tdata,   // [15:0] average_rpm, [23:16] fault_count
    output logic             m_tuser    // [0] average_changed
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_SUB,
        ST_ADD,
        ST_DIV,
        ST_DONE
    } state_t;

    state_t                    state_reg, state_next;
    smafc_pkg::cnt_t           count_reg, count_next;
    smafc_pkg::idx_t           oldest_reg, oldest_next;
    smafc_pkg::sum_t           sum_reg, sum_next;
    logic [smafc_pkg::AVG_W-1:0]   avg_reg, avg_next;
    logic [smafc_pkg::FAULT_W-1:0] fault_reg, fault_next;
    smafc_pkg::sample_t        samp_reg, samp_next;
    logic                      ok_reg, ok_next;
    smafc_pkg::sum_t           quo_reg, quo_next;
    logic [smafc_pkg::REM_W-1:0]   rem_reg, rem_next;
    logic [smafc_pkg::STEP_W-1:0]  step_reg, step_next;
    logic                      m_valid_reg, m_valid_next;
    logic [23:0]               m_data_reg, m_data_next;
    logic                      m_user_reg, m_user_next;

    logic                      ram_we;
    smafc_pkg::idx_t           ram_addr;
    smafc_pkg::sample_t        ram_wdata;
    smafc_pkg::sample_t        ram_rdata;

    logic [smafc_pkg::REM_W-1:0]   rem_shift;
    logic                      s_fire;
    logic                      full;
    logic                      out_free;
    logic                      avg_changed;

    smafc_ram #(
        .WIDTH (smafc_pkg::SAMPLE_BITS),
        .DEPTH (smafc_pkg::WINDOW_LEN)
    ) u_ring (
        .clk   (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign full     = (count_reg == smafc_pkg::CNT_W'(smafc_pkg::WINDOW_LEN));
    assign out_free = !m_valid_reg || m_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    assign rem_shift   = {rem_reg[smafc_pkg::REM_W-2:0], quo_reg[smafc_pkg::SUM_W-1]};
    assign avg_changed = ok_reg && (quo_reg[smafc_pkg::AVG_W-1:0] != avg_reg);

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        oldest_next  = oldest_reg;
        sum_next     = sum_reg;
        avg_next     = avg_reg;
        fault_next   = fault_reg;
        samp_next    = samp_reg;
        ok_next      = ok_reg;
        quo_next     = quo_reg;
        rem_next     = rem_reg;
        step_next    = step_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;
        ram_we       = 1'b0;
        ram_addr     = oldest_reg;
        ram_wdata    = samp_reg;

        if (m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    samp_next = s_tdata[smafc_pkg::SAMPLE_BITS-1:0];
                    ok_next   = s_tuser;
                    if (s_tuser) begin
                        fault_next = '0;
                        state_next = full ? ST_READ : ST_ADD;
                    end else begin
                        if (fault_reg != smafc_pkg::FAULT_W'(smafc_pkg::FAULT_MAX)) begin
                            fault_next = fault_reg + 1'b1;
                        end
                        state_next = ST_DONE;
                    end
                end
            end
            ST_READ: begin
                // The oldest sample is fetched; its data is ready in the next cycle.
                state_next = ST_SUB;
            end
            ST_SUB: begin
                ram_we    = 1'b1;
                sum_next  = sum_reg - smafc_pkg::SUM_W'(ram_rdata)
                          + smafc_pkg::SUM_W'(samp_reg);
                if (oldest_reg == smafc_pkg::IDX_W'(smafc_pkg::WINDOW_LEN - 1)) begin
                    oldest_next = '0;
                end else begin
                    oldest_next = oldest_reg + 1'b1;
                end
                quo_next   = sum_next;
                rem_next   = '0;
                step_next  = smafc_pkg::STEP_W'(smafc_pkg::SUM_W - 1);
                state_next = ST_DIV;
            end
            ST_ADD: begin
                // While the window is filling, the oldest entry stays in slot zero,
                // so the free slot is the entry count.
                ram_we     = 1'b1;
                ram_addr   = count_reg[smafc_pkg::IDX_W-1:0];
                sum_next   = sum_reg + smafc_pkg::SUM_W'(samp_reg);
                count_next = count_reg + 1'b1;
                quo_next   = sum_next;
                rem_next   = '0;
                step_next  = smafc_pkg::STEP_W'(smafc_pkg::SUM_W - 1);
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (rem_shift >= {1'b0, count_reg}) begin
                    rem_next = rem_shift - {1'b0, count_reg};
                    quo_next = {quo_reg[smafc_pkg::SUM_W-2:0], 1'b1};
                end else begin
                    rem_next = rem_shift;
                    quo_next = {quo_reg[smafc_pkg::SUM_W-2:0], 1'b0};
                end
                step_next = step_reg - 1'b1;
                if (step_reg == '0) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    if (ok_reg) begin
                        avg_next = quo_reg[smafc_pkg::AVG_W-1:0];
                    end
                    m_valid_next = 1'b1;
                    m_data_next  = {fault_next, avg_next};
                    m_user_next  = avg_changed;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            oldest_reg  <= '0;
            sum_reg     <= '0;
            avg_reg     <= '0;
            fault_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            oldest_reg  <= oldest_next;
            sum_reg     <= sum_next;
            avg_reg     <= avg_next;
            fault_reg   <= fault_next;
            m_valid_reg <= m_valid_next;
        end
        samp_reg   <= samp_next;
        ok_reg     <= ok_next;
        quo_reg    <= quo_next;
        rem_reg    <= rem_next;
        step_reg   <= step_next;
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
    end

`ifndef SYNTH
    // The window never holds more entries than it has slots.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= smafc_pkg::CNT_W'(smafc_pkg::WINDOW_LEN))
        else $error("entry count exceeds window length");

    // The oldest pointer only moves once the window is full.
    a_oldest_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (oldest_reg != '0) |-> full)
        else $error("oldest pointer moved before window filled");

    // A result that carries a fault count came from a failed read and cannot change the average.
    a_fault_no_change: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (m_data_reg[23:16] != '0)) |-> !m_user_reg)
        else $error("average changed on a failed read");

    // Once the divider starts, it finishes before the result is presented.
    a_div_exit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV && step_reg == '0) |=> (state_reg == ST_DONE))
        else $error("divider did not hand over to result stage");
`endif

endmodule
`default_nettype wire

// File: bench/testbench.sv
`timescale 1ns / 100ps

module testbench;

    typedef struct packed {
        logic        read_ok;
        logic [15:0] rpm;
        logic        drain_first;   // hold off until every result is back
    } speed_read_t;

    typedef struct packed {
        logic [smafc_pkg::AVG_W-1:0]   avg;
        logic                          changed;
        logic [smafc_pkg::FAULT_W-1:0] fault;
    } speed_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        m_tuser;

    speed_read_t   pending_reads[$];
    speed_result_t expected_readings[$];

    // Own copy of the speed window and fault state.
    smafc_pkg::sample_t            win_ring [smafc_pkg::WINDOW_LEN];
    smafc_pkg::cnt_t               win_count = '0;
    smafc_pkg::idx_t               win_oldest = '0;
    smafc_pkg::sum_t               win_sum = '0;
    logic [smafc_pkg::AVG_W-1:0]   win_average = '0;
    logic [smafc_pkg::FAULT_W-1:0] fail_tally = '0;

    int n_sent = 0;
    int n_checked = 0;
    int n_results = 0;
    int n_errors = 0;
    int gap_left = 0;
    int stall_left = 0;
    bit calm_s = 1'b0;
    bit calm_m = 1'b0;

    speed_moving_average_with_fault_count_core DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("result %0d: %s is %0h, expected %0h", n_results, what, got, want);
        n_errors++;
    endtask

    // Occasionally flips between calm stretches with no waiting and busy ones.
    function automatic int draw_wait(inout bit calm);
        if ($urandom_range(0, 47) == 0)
            calm = !calm;
        return calm ? 0 : $urandom_range(0, 11);
    endfunction

    task automatic predict_speed_read(input logic ok, input logic [15:0] rpm);
        smafc_pkg::sample_t          s;
        smafc_pkg::idx_t             slot;
        smafc_pkg::sum_t             quot;
        logic [smafc_pkg::AVG_W-1:0] avg;
        speed_result_t               r;
        s = smafc_pkg::sample_t'(rpm);
        r.changed = 1'b0;
        if (ok) begin
            fail_tally = '0;
            if (win_count >= smafc_pkg::WINDOW_LEN) begin
                win_sum = win_sum - win_ring[win_oldest];
                win_ring[win_oldest] = s;
                win_oldest = (int'(win_oldest) == smafc_pkg::WINDOW_LEN - 1) ? '0
                           : win_oldest + 1'b1;
            end else begin
                slot = smafc_pkg::idx_t'((int'(win_oldest) + int'(win_count))
                                         % smafc_pkg::WINDOW_LEN);
                win_ring[slot] = s;
                win_count = win_count + 1'b1;
            end
            win_sum = win_sum + s;
            quot = win_sum / smafc_pkg::sum_t'(win_count);
            avg = quot[smafc_pkg::AVG_W-1:0];
            if (avg != win_average) begin
                win_average = avg;
                r.changed = 1'b1;
            end
        end else if (fail_tally < smafc_pkg::FAULT_MAX) begin
            fail_tally = fail_tally + 1'b1;
        end
        r.avg = win_average;
        r.fault = fail_tally;
        expected_readings.insert(expected_readings.size(), r);
    endtask

    task automatic queue_read(input logic ok, input logic [15:0] rpm, input logic drain);
        speed_read_t it;
        it.read_ok = ok;
        it.rpm = rpm;
        it.drain_first = drain;
        pending_reads.insert(pending_reads.size(), it);
    endtask

    function automatic logic [15:0] pick_rpm(input int style, input logic [15:0] centre);
        case (style)
            0: return 16'($urandom);
            1: return 16'hFFFF - 16'($urandom_range(0, 255));
            2: return 16'($urandom_range(0, 15));
            default: return centre + 16'($urandom_range(0, 3));
        endcase
    endfunction

    always @(posedge aclk) begin : drive_reads
        logic next_valid;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            gap_left = 0;
        end else begin
            next_valid = s_tvalid && !s_tready;
            if (s_tvalid && s_tready) begin
                predict_speed_read(s_tuser, s_tdata);
                n_sent++;
            end
            if (!next_valid) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_reads.size() > 0 &&
                             !(pending_reads[0].drain_first && n_checked != n_sent)) begin
                    s_tuser <= pending_reads[0].read_ok;
                    s_tdata <= pending_reads[0].rpm;
                    pending_reads.delete(0);
                    next_valid = 1'b1;
                    gap_left = draw_wait(calm_s);
                end
            end
            s_tvalid <= next_valid;
        end
    end

    always @(posedge aclk) begin : check_results
        speed_result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
            stall_left = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                n_results++;
                if (expected_readings.size() == 0) begin
                    report_mismatch("unexpected beat, average", m_tdata[15:0], 0);
                end else begin
                    want = expected_readings[0];
                    expected_readings.delete(0);
                    if (m_tdata[15:0] !== want.avg)
                        report_mismatch("average_rpm", m_tdata[15:0], want.avg);
                    if (m_tuser !== want.changed)
                        report_mismatch("average_changed", m_tuser, want.changed);
                    if (m_tdata[23:16] !== want.fault)
                        report_mismatch("fault_count", m_tdata[23:16], want.fault);
                    n_checked <= n_checked + 1;
                end
                stall_left = draw_wait(calm_m);
            end else if (stall_left > 0) begin
                stall_left--;
            end
            m_tready <= (stall_left == 0);
        end
    end

    initial begin
        int          good_pct;
        int          style;
        logic [15:0] centre;

        // Directed: zero first sample, extremes, failures between good reads.
        queue_read(1'b1, 16'h0000, 1'b0);
        queue_read(1'b1, 16'hFFFF, 1'b0);
        queue_read(1'b1, 16'h0001, 1'b0);
        queue_read(1'b0, 16'hFFFF, 1'b0);
        queue_read(1'b0, 16'h0000, 1'b0);
        queue_read(1'b1, 16'h0000, 1'b0);
        queue_read(1'b1, 16'hAAAA, 1'b0);
        queue_read(1'b1, 16'h5555, 1'b0);
        queue_read(1'b0, 16'h1234, 1'b0);
        queue_read(1'b1, 16'hFFFF, 1'b0);
        queue_read(1'b1, 16'hFFFF, 1'b0);
        queue_read(1'b1, 16'hFFFF, 1'b0);
        queue_read(1'b0, 16'hFFFF, 1'b0);
        queue_read(1'b1, 16'h8000, 1'b0);
        queue_read(1'b1, 16'h7FFF, 1'b0);
        queue_read(1'b1, 16'h0000, 1'b0);

        // A full window of the largest sample, then zeros, then a constant.
        for (int i = 0; i < 55; i++)
            queue_read(1'b1, 16'hFFFF, 1'b0);
        for (int i = 0; i < 55; i++)
            queue_read(1'b1, 16'h0000, i == 0);
        centre = 16'($urandom);
        for (int i = 0; i < 55; i++)
            queue_read(1'b1, centre, 1'b0);

        // A long run of failed reads saturates the fault count.
        for (int i = 0; i < 262; i++)
            queue_read(1'b0, 16'($urandom), i == 0);
        queue_read(1'b1, 16'($urandom), 1'b0);

        for (int seg = 0; seg < 5; seg++) begin
            good_pct = 50 + 10 * seg;
            style = $urandom_range(0, 3);
            centre = 16'($urandom);
            for (int i = 0; i < 100; i++) begin
                if ($urandom_range(0, 9) == 0)
                    style = $urandom_range(0, 3);
                queue_read($urandom_range(1, 100) <= good_pct, pick_rpm(style, centre),
                           i == 50);
            end
        end

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        do @(negedge aclk);
        while (pending_reads.size() != 0 || s_tvalid || n_checked != n_sent);
        repeat (60) @(posedge aclk);

        if (expected_readings.size() != 0)
            report_mismatch("beats still outstanding", 0, expected_readings.size());
        if (n_errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/smafc_pkg.sv
rtl/smafc_ram.sv
rtl/speed_moving_average_with_fault_count_core.sv
bench/testbench.sv
